// ----- hw/rtl/dhpbl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and result decoding for the DSP host-port boot loader.
package dhpbl_pkg;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_ADDR = 2'd1;
	localparam logic [1:0] REG_DATA = 2'd2;

	localparam logic [15:0] CTRL_INIT_WORD = 16'h0808;
	localparam logic [15:0] END_ADDR_WORD  = 16'h007E;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LEN,
		PH_ADDR_HI,
		PH_ADDR_LO,
		PH_SKIP,
		PH_WORD_HI,
		PH_WORD_LO,
		PH_WAIT_READ,
		PH_WAIT_ADDR,
		PH_TRAIL
	} phase_t;

	typedef enum logic [2:0] {
		CMD_CTRL,
		CMD_START_END,
		CMD_END,
		CMD_WORD,
		CMD_TRIAL,
		CMD_ADDR_RD,
		CMD_FAIL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] addr;
		logic [15:0] word;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  access_reg;
		logic        access_write;
		logic [15:0] access_data;
		logic        load_failed;
		logic        image_end;
	} result_t;

	function automatic logic [1:0] cmd_last_step(input cmd_kind_t kind);
		logic [1:0] n;
		unique case (kind)
			CMD_START_END: n = 2'd2;
			CMD_END:       n = 2'd1;
			CMD_WORD:      n = 2'd3;
			CMD_TRIAL:     n = 2'd2;
			default:       n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic result_t cmd_result(input cmd_t c, input logic [1:0] step,
		input logic [15:0] entry);
		result_t r;
		logic [1:0] idx;
		r = '0;
		idx = (c.kind == CMD_TRIAL) ? step + 2'd1 : step;
		unique case (c.kind)
			CMD_CTRL: begin
				r.access_reg = REG_CTRL;
				r.access_write = 1'b1;
				r.access_data = CTRL_INIT_WORD;
			end
			CMD_START_END, CMD_END: begin
				if (c.kind == CMD_START_END && step == 2'd0) begin
					r.access_reg = REG_CTRL;
					r.access_write = 1'b1;
					r.access_data = CTRL_INIT_WORD;
				end else if (step == cmd_last_step(c.kind)) begin
					r.access_reg = REG_DATA;
					r.access_write = 1'b1;
					r.access_data = entry;
					r.image_end = 1'b1;
				end else begin
					r.access_reg = REG_ADDR;
					r.access_write = 1'b1;
					r.access_data = END_ADDR_WORD;
				end
			end
			CMD_WORD, CMD_TRIAL: begin
				unique case (idx)
					2'd0, 2'd1: begin
						r.access_reg = REG_ADDR;
						r.access_write = 1'b1;
						r.access_data = c.addr;
					end
					2'd2: begin
						r.access_reg = REG_DATA;
						r.access_write = 1'b1;
						r.access_data = c.word;
					end
					default: begin
						r.access_reg = REG_DATA;
					end
				endcase
			end
			CMD_ADDR_RD: begin
				r.access_reg = REG_ADDR;
			end
			CMD_FAIL: begin
				r.load_failed = 1'b1;
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/dhpbl_front.sv -----
`timescale 1ns / 1ps
// Image parser: parses each item in the cycle it is taken and issues access commands.
module dhpbl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic            mode,
	input  logic [15:0]     value,
	output logic            cmd_push,
	output dhpbl_pkg::cmd_t cmd
);
	import dhpbl_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] load_address_q, load_address_d;
	logic [7:0]  word_high_q, word_high_d;
	logic [15:0] current_word_q, current_word_d;
	logic [6:0]  words_left_q, words_left_d;
	logic        retry_used_q, retry_used_d;
	logic        halted_q, halted_d;
	logic [7:0]  byte_in;
	logic        act;
	logic [6:0]  words_dec;

	assign byte_in = value[7:0];
	assign act = take && !halted_q;
	assign words_dec = words_left_q - 7'd1;

	always_comb begin
		phase_d = phase_q;
		load_address_d = load_address_q;
		word_high_d = word_high_q;
		current_word_d = current_word_q;
		words_left_d = words_left_q;
		retry_used_d = retry_used_q;
		halted_d = halted_q;
		if (act && !mode) begin
			unique case (phase_q)
				PH_IDLE, PH_LEN: begin
					if (byte_in == 8'd0) begin
						phase_d = PH_IDLE;
					end else begin
						words_left_d = byte_in[7:1];
						phase_d = PH_ADDR_HI;
					end
				end
				PH_ADDR_HI: begin
					load_address_d = {byte_in, 8'h00};
					phase_d = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					load_address_d = load_address_q + {8'h00, byte_in} - 16'd1;
					phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					phase_d = (words_left_q == 7'd0) ? PH_TRAIL : PH_WORD_HI;
				end
				PH_WORD_HI: begin
					word_high_d = byte_in;
					phase_d = PH_WORD_LO;
				end
				PH_WORD_LO: begin
					current_word_d = {word_high_q, byte_in};
					retry_used_d = 1'b0;
					phase_d = PH_WAIT_READ;
				end
				PH_TRAIL: begin
					phase_d = PH_LEN;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end else if (act && mode) begin
			if (phase_q == PH_WAIT_READ) begin
				if (value == current_word_q) begin
					phase_d = PH_WAIT_ADDR;
				end else if (!retry_used_q) begin
					retry_used_d = 1'b1;
				end else begin
					halted_d = 1'b1;
				end
			end else if (phase_q == PH_WAIT_ADDR) begin
				load_address_d = value - 16'd1;
				words_left_d = words_dec;
				phase_d = (words_dec == 7'd0) ? PH_TRAIL : PH_WORD_HI;
			end
		end
	end

	always_comb begin
		cmd_push = 1'b0;
		cmd.kind = CMD_CTRL;
		cmd.addr = load_address_q;
		cmd.word = current_word_q;
		if (act && !mode) begin
			unique case (phase_q)
				PH_IDLE: begin
					cmd_push = 1'b1;
					cmd.kind = (byte_in == 8'd0) ? CMD_START_END : CMD_CTRL;
				end
				PH_LEN: begin
					cmd_push = (byte_in == 8'd0);
					cmd.kind = CMD_END;
				end
				PH_WORD_LO: begin
					cmd_push = 1'b1;
					cmd.kind = CMD_WORD;
					cmd.word = {word_high_q, byte_in};
				end
				default: begin
					cmd_push = 1'b0;
				end
			endcase
		end else if (act && mode && phase_q == PH_WAIT_READ) begin
			cmd_push = 1'b1;
			if (value == current_word_q) begin
				cmd.kind = CMD_ADDR_RD;
			end else if (!retry_used_q) begin
				cmd.kind = CMD_TRIAL;
			end else begin
				cmd.kind = CMD_FAIL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			load_address_q <= '0;
			word_high_q <= '0;
			current_word_q <= '0;
			words_left_q <= '0;
			retry_used_q <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			load_address_q <= load_address_d;
			word_high_q <= word_high_d;
			current_word_q <= current_word_d;
			words_left_q <= words_left_d;
			retry_used_q <= retry_used_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ----- hw/rtl/dhpbl_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the image parser and the access sequencer.
module dhpbl_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dhpbl_pkg::cmd_t wdata,
	output logic            full,
	input  logic            pop,
	output dhpbl_pkg::cmd_t rdata,
	output logic            empty
);
	import dhpbl_pkg::*;

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/dhpbl_back.sv -----
`timescale 1ns / 1ps
// Access sequencer: expands commands into accesses, one per cycle unless stalled.
module dhpbl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dhpbl_pkg::cmd_t   cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  logic [15:0]       entry_address,
	output dhpbl_pkg::result_t res,
	output logic              res_last,
	output logic              empty,
	input  logic              pop
);
	import dhpbl_pkg::*;

	logic [1:0] step_q;
	logic       out_valid_q;
	result_t    res_q;
	logic       last_q;
	logic       advance;
	logic       fire;
	logic       at_last;

	assign advance = !out_valid_q || pop;
	assign fire = advance && cmd_valid;
	assign at_last = (step_q == cmd_last_step(cmd.kind));
	assign cmd_pop = fire && at_last;
	assign empty = !out_valid_q;
	assign res = res_q;
	assign res_last = last_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= cmd_result(cmd, step_q, entry_address);
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				step_q <= at_last ? 2'd0 : step_q + 2'd1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/dsp_host_port_boot_loader.sv -----
`timescale 1ns / 1ps
// Top level of the DSP host-port boot loader.
// The loader takes one item per cycle whenever full is low: image bytes and
// read responses are parsed in the cycle they arrive and turned into access
// commands, which wait in a two-entry command queue. The access sequencer
// behind the queue sends one host-port access per cycle to an output
// register whenever that register is empty or popped; the low byte of a
// word causes four accesses, and the queue depth sets how far the input
// side can run ahead of the result side. The entry address register must
// be written only while the loader is idle.
module dsp_host_port_boot_loader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [15:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  access_reg,
	output logic        access_write,
	output logic [15:0] access_data,
	output logic        load_failed,
	output logic        image_end,
	output logic        last,
	input  logic        cfg_write,
	input  logic [15:0] cfg_data
);
	import dhpbl_pkg::*;

	logic [15:0] entry_address_q;
	logic        take;
	logic        cmd_push;
	cmd_t        cmd_in;
	cmd_t        cmd_head;
	logic        cmdq_empty;
	logic        cmd_pop;
	result_t     res;

	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_address_q <= '0;
		end else if (cfg_write) begin
			entry_address_q <= cfg_data;
		end
	end

	dhpbl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.mode     (mode),
		.value    (value),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	dhpbl_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmdq_empty)
	);

	dhpbl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_head),
		.cmd_valid     (!cmdq_empty),
		.cmd_pop       (cmd_pop),
		.entry_address (entry_address_q),
		.res           (res),
		.res_last      (last),
		.empty         (empty),
		.pop           (pop)
	);

	assign access_reg = res.access_reg;
	assign access_write = res.access_write;
	assign access_data = res.access_data;
	assign load_failed = res.load_failed;
	assign image_end = res.image_end;

endmodule

// ----- tb/dhpbl_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the host-port accesses of the boot loader and compares them.
module dhpbl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        mode,
	input  logic [15:0] value,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  access_reg,
	input  logic        access_write,
	input  logic [15:0] access_data,
	input  logic        load_failed,
	input  logic        image_end,
	input  logic        last,
	input  logic        cfg_write,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          accesses_checked
);
	import dhpbl_pkg::*;

	typedef struct packed {
		result_t acc;
		logic    last;
	} port_access_t;

	port_access_t expected_accesses[$];
	port_access_t item_accesses[$];

	phase_t      load_phase;
	logic [15:0] entry_addr;
	logic [15:0] load_addr;
	logic [7:0]  hi_byte;
	logic [15:0] word_value;
	logic [6:0]  words_remaining;
	logic        retried;
	logic        halted;

	task automatic add_access(input logic [1:0] reg_code, input logic wr,
		input logic [15:0] data, input logic failed, input logic done);
		port_access_t a;
		a.acc.access_reg = reg_code;
		a.acc.access_write = wr;
		a.acc.access_data = data;
		a.acc.load_failed = failed;
		a.acc.image_end = done;
		a.last = 1'b0;
		item_accesses.push_back(a);
	endtask

	task automatic add_trial();
		add_access(REG_ADDR, 1'b1, load_addr, 1'b0, 1'b0);
		add_access(REG_DATA, 1'b1, word_value, 1'b0, 1'b0);
		add_access(REG_DATA, 1'b0, 16'h0000, 1'b0, 1'b0);
	endtask

	task automatic take_length(input logic [7:0] b);
		if (b == 8'h00) begin
			add_access(REG_ADDR, 1'b1, END_ADDR_WORD, 1'b0, 1'b0);
			add_access(REG_DATA, 1'b1, entry_addr, 1'b0, 1'b1);
			load_phase = PH_IDLE;
		end else begin
			words_remaining = b[7:1];
			load_phase = PH_ADDR_HI;
		end
	endtask

	task automatic predict_item(input logic m, input logic [15:0] v);
		logic [7:0] b;
		port_access_t a;
		int n;
		b = v[7:0];
		item_accesses.delete();
		if (!halted) begin
			if (!m) begin
				case (load_phase)
					PH_IDLE: begin
						add_access(REG_CTRL, 1'b1, CTRL_INIT_WORD, 1'b0, 1'b0);
						take_length(b);
					end
					PH_LEN: take_length(b);
					PH_ADDR_HI: begin
						load_addr = {b, 8'h00};
						load_phase = PH_ADDR_LO;
					end
					PH_ADDR_LO: begin
						load_addr = load_addr + {8'h00, b} - 16'd1;
						load_phase = PH_SKIP;
					end
					PH_SKIP: load_phase = (words_remaining == 7'd0) ? PH_TRAIL : PH_WORD_HI;
					PH_WORD_HI: begin
						hi_byte = b;
						load_phase = PH_WORD_LO;
					end
					PH_WORD_LO: begin
						word_value = {hi_byte, b};
						retried = 1'b0;
						add_access(REG_ADDR, 1'b1, load_addr, 1'b0, 1'b0);
						add_trial();
						load_phase = PH_WAIT_READ;
					end
					PH_TRAIL: load_phase = PH_LEN;
					default: ;
				endcase
			end else if (load_phase == PH_WAIT_READ) begin
				if (v == word_value) begin
					add_access(REG_ADDR, 1'b0, 16'h0000, 1'b0, 1'b0);
					load_phase = PH_WAIT_ADDR;
				end else if (!retried) begin
					retried = 1'b1;
					add_trial();
				end else begin
					add_access(REG_CTRL, 1'b0, 16'h0000, 1'b1, 1'b0);
					halted = 1'b1;
				end
			end else if (load_phase == PH_WAIT_ADDR) begin
				load_addr = v - 16'd1;
				words_remaining = words_remaining - 7'd1;
				load_phase = (words_remaining == 7'd0) ? PH_TRAIL : PH_WORD_HI;
			end
		end
		n = item_accesses.size();
		for (int i = 0; i < n; i++) begin
			a = item_accesses[i];
			a.last = (i == n - 1);
			expected_accesses.push_back(a);
		end
	endtask

	task automatic check_access();
		port_access_t seen;
		port_access_t want;
		seen.acc.access_reg = access_reg;
		seen.acc.access_write = access_write;
		seen.acc.access_data = access_data;
		seen.acc.load_failed = load_failed;
		seen.acc.image_end = image_end;
		seen.last = last;
		accesses_checked++;
		if (expected_accesses.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: unexpected access reg=%0d wr=%0b data=%h",
					access_reg, access_write, access_data);
				$display("       fail=%0b end=%0b last=%0b",
					load_failed, image_end, last);
			end
		end else begin
			want = expected_accesses.pop_front();
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: access %0d expected reg=%0d wr=%0b data=%h",
						accesses_checked, want.acc.access_reg, want.acc.access_write,
						want.acc.access_data);
					$display("       expected fail=%0b end=%0b last=%0b",
						want.acc.load_failed, want.acc.image_end, want.last);
					$display("       actual reg=%0d wr=%0b data=%h fail=%0b end=%0b last=%0b",
						access_reg, access_write, access_data, load_failed, image_end, last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_addr = 16'h0000;
			load_phase = PH_IDLE;
			load_addr = 16'h0000;
			hi_byte = 8'h00;
			word_value = 16'h0000;
			words_remaining = 7'd0;
			retried = 1'b0;
			halted = 1'b0;
			expected_accesses.delete();
			mismatches = 0;
			accesses_checked = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty)
				check_access();
			if (cfg_write)
				entry_addr = cfg_data;
			if (push && !full)
				predict_item(mode, value);
			outstanding = expected_accesses.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench top that drives image bytes, read responses and entry-address writes.
module tb;
	import dhpbl_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        mode = 1'b0;
	logic [15:0] value = 16'h0000;
	logic        pop = 1'b0;
	logic        cfg_write = 1'b0;
	logic [15:0] cfg_data = 16'h0000;
	logic        full;
	logic        empty;
	logic [1:0]  access_reg;
	logic        access_write;
	logic [15:0] access_data;
	logic        load_failed;
	logic        image_end;
	logic        last;

	int mismatches;
	int outstanding;
	int accesses_checked;
	int items_sent = 0;
	int items_ignored = 0;
	int entry_settings = 0;
	int stall_cycles = 0;
	bit sender_bursts = 1'b1;
	bit receiver_bursts = 1'b1;
	bit noise_on = 1'b0;
	bit hold_request = 1'b0;

	always #5 clk = ~clk;

	dsp_host_port_boot_loader dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.value(value),
		.empty(empty),
		.pop(pop),
		.access_reg(access_reg),
		.access_write(access_write),
		.access_data(access_data),
		.load_failed(load_failed),
		.image_end(image_end),
		.last(last),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	dhpbl_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.value(value),
		.empty(empty),
		.pop(pop),
		.access_reg(access_reg),
		.access_write(access_write),
		.access_data(access_data),
		.load_failed(load_failed),
		.image_end(image_end),
		.last(last),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.accesses_checked(accesses_checked)
	);

	task automatic send_item(input logic m, input logic [15:0] v);
		int gap;
		if (sender_bursts && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (noise_on && $urandom_range(0, 11) == 0) begin
			send_item(1'b1, 16'($urandom));
			items_ignored++;
		end
		send_item(1'b0, {8'($urandom_range(0, 255)), b});
	endtask

	task automatic send_word(input logic [15:0] w, input int bad_tries);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
		if (noise_on && $urandom_range(0, 7) == 0) begin
			send_item(1'b0, 16'($urandom));
			items_ignored++;
		end
		repeat (bad_tries) send_item(1'b1, w ^ 16'($urandom_range(1, 65535)));
		if (bad_tries < 2) begin
			send_item(1'b1, w);
			send_item(1'b1, 16'($urandom));
		end
	endtask

	task automatic send_image(input int records);
		int len;
		for (int r = 0; r < records; r++) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			send_byte(8'(len));
			repeat (3) send_byte(8'($urandom_range(0, 255)));
			for (int w = 0; w < len / 2; w++)
				send_word(16'($urandom), ($urandom_range(0, 6) == 0) ? 1 : 0);
			send_byte(8'($urandom_range(0, 255)));
		end
		send_byte(8'h00);
	endtask

	task automatic set_entry(input logic [15:0] v);
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		entry_settings++;
	endtask

	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				pop <= 1'b0;
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (receiver_bursts && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_entry(16'hFFFF);

		// Odd-length record at address zero, which wraps to the top of memory.
		send_byte(8'h05);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_item(1'b1, 16'h1234);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b1, 16'h0000);
		send_byte(8'h00);
		send_byte(8'h00);
		send_item(1'b1, 16'h0000);
		send_item(1'b1, 16'hFFFF);
		send_byte(8'hAA);
		// Single-byte record loads nothing, then the image ends.
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'h55);
		send_byte(8'h7F);
		send_byte(8'h00);
		// An image that is empty from its first byte.
		send_byte(8'h00);
		items_ignored += 2;

		set_entry(16'h0000);
		noise_on = 1'b1;
		hold_request = 1'b1;
		send_image(3);

		set_entry(16'($urandom));
		while (items_sent < 125) begin
			send_image($urandom_range(1, 3));
			if ($urandom_range(0, 1) == 0)
				set_entry(16'($urandom));
		end

		sender_bursts = 1'b0;
		receiver_bursts = 1'b0;
		set_entry(16'h8001);
		send_image(2);

		// A word that mismatches twice halts the loader until reset.
		send_byte(8'h02);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
		send_word(16'($urandom), 2);
		repeat (6) begin
			send_item(1'($urandom_range(0, 1)), 16'($urandom));
			items_ignored++;
		end
		push <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d items (%0d out of place or after the halt); checked %0d accesses.",
			items_sent, items_ignored, accesses_checked);
		$display("Entry address written %0d times; retries, a long receiver stall %s",
			entry_settings, "and a halt were hit.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- dsp_host_port_boot_loader.f -----
hw/rtl/dhpbl_pkg.sv
hw/rtl/dhpbl_front.sv
hw/rtl/dhpbl_cmd_fifo.sv
hw/rtl/dhpbl_back.sv
hw/rtl/dsp_host_port_boot_loader.sv
tb/dhpbl_checker.sv
tb/tb.sv
